[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the rtl folder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sida_pkg.sv]
// ---------------------------------------------------------------------------
// sida_pkg
// Character codes and types shared by the decimal text converter
// ---------------------------------------------------------------------------
package sida_pkg;

   // seven-bit ascii code
   typedef logic [6:0] char_type;

   // one bcd digit
   typedef logic [3:0] digit_type;

   localparam char_type CHAR_MINUS = 7'd45;
   localparam char_type CHAR_ZERO  = 7'd48;
   localparam char_type CHAR_NINE  = 7'd57;

   // double dabble correction threshold and offset
   localparam digit_type DIGIT_FIVE  = 4'd5;
   localparam digit_type DIGIT_THREE = 4'd3;

endpackage

[rtl/signed_int_to_decimal_ascii.sv]
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed integer to decimal ascii text, one character per response
// ---------------------------------------------------------------------------
// A request carries one two's-complement value of VALUE_BITS bits. The block
// answers with its decimal text, most significant character first, a '-' in
// front of negative values, and rsp_last set on the final digit; zero gives
// the single character '0'. The magnitude goes through a shift-and-add-3
// (double dabble) unit, one bit per cycle, then the leading digit is located
// and the characters (up to 11 at 32 bits) are sent one per cycle while
// rsp_stall is low. req_stall stays high from an accepted request through
// conversion, the leading-digit search and the loading of its last
// character, so a new request is taken only once the previous one is
// through, in an idle cycle. The last character may still sit in the output
// register while the next request is taken.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_BITS-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [6:0]                    rsp_character,
   output logic                          rsp_last
);

`include "assert_macros.svh"

   // decimal digits needed for 2^(VALUE_BITS-1)
   localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_W = NDIG * 4;
   localparam int IDX_W = $clog2(NDIG);
   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_FIND = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sida_pkg::char_type    rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [BCD_W-1:0]      bcd_adj;
   logic [IDX_W-1:0]      lead_idx;
   sida_pkg::digit_type   cur_digit;
   logic                  out_load;
   logic                  req_take;
   logic                  rsp_is_minus;
   logic                  rsp_is_digit;

   // add-3 correction on every digit before the shift
   always_comb begin
      for (int d = 0; d < NDIG; d++) begin
         if (bcd_ff[d*4 +: 4] >= sida_pkg::DIGIT_FIVE) begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + sida_pkg::DIGIT_THREE;
         end else begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   // highest nonzero digit, digit zero when the value is zero
   always_comb begin
      lead_idx = '0;
      for (int d = 1; d < NDIG; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            lead_idx = IDX_W'(d);
         end
      end
   end

   assign cur_digit = bcd_ff[idx_ff*4 +: 4];
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign out_load  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_in = req_value[VALUE_BITS-1];
               if (req_value[VALUE_BITS-1]) begin
                  mag_in = ~$unsigned(req_value) + VALUE_BITS'(1);
               end else begin
                  mag_in = $unsigned(req_value);
               end
               bcd_in   = '0;
               cnt_in   = CNT_W'(VALUE_BITS);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            idx_in   = lead_idx;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_char_in = sida_pkg::CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  rsp_char_in = sida_pkg::CHAR_ZERO + {3'b000, cur_digit};
                  rsp_last_in = (idx_ff == '0);
                  idx_in      = idx_ff - IDX_W'(1);
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // character classes seen by the checks
   assign rsp_is_minus = (rsp_char_ff == sida_pkg::CHAR_MINUS);
   assign rsp_is_digit = (rsp_char_ff >= sida_pkg::CHAR_ZERO) &&
                         (rsp_char_ff <= sida_pkg::CHAR_NINE);

   // checks
   `ASSERT_NEXT(a_take_starts_conv, clock, reset, req_take, state_ff == ST_CONV, "request lost")
   `ASSERT_SAME(a_conv_count, clock, reset, state_ff == ST_CONV, cnt_ff != '0, "count ran out")
   `ASSERT_SAME(a_char_legal, clock, reset, rsp_valid_ff, rsp_is_minus || rsp_is_digit, "bad char")
   `ASSERT_SAME(a_minus_not_last, clock, reset, rsp_valid_ff && rsp_is_minus, !rsp_last_ff, "sign last")

endmodule

[tb/sv/decimal_text_checker.sv]
// ---------------------------------------------------------------------------
// decimal_text_checker
// Watches both channels of the decimal text converter and checks responses
// ---------------------------------------------------------------------------
// Every accepted request is turned into its expected decimal text: a leading
// '-' for negative values, then the digits most significant first, with last
// set on the final digit. Each accepted response is compared field by field
// with the oldest expected character. The failure count and the number of
// characters still outstanding go back to the testbench top.
// ---------------------------------------------------------------------------
module decimal_text_checker #(
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [VALUE_BITS-1:0]  req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [6:0]                    rsp_character,
   input  logic                          rsp_last,
   output int                            error_count,
   output int                            pending_count
);

   typedef struct packed {
      sida_pkg::char_type character;
      logic               last;
   } text_char_type;

   // characters still owed by the block, oldest first
   text_char_type expected_text[$];
   int            failures = 0;

   // append the decimal text of one value to the expected characters
   function automatic void predict_text(logic [VALUE_BITS-1:0] value);
      logic                  negative;
      logic [VALUE_BITS-1:0] magnitude;
      sida_pkg::digit_type   digits[$];
      text_char_type         entry;
      negative  = value[VALUE_BITS-1];
      // unsigned magnitude, so the most negative value needs no patch
      magnitude = negative ? (~value + 1'b1) : value;
      // zero still gives one digit
      do begin
         digits.push_front(sida_pkg::digit_type'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (negative) begin
         entry.character = sida_pkg::CHAR_MINUS;
         entry.last      = 1'b0;
         expected_text.push_back(entry);
      end
      foreach (digits[i]) begin
         entry.character = sida_pkg::CHAR_ZERO + sida_pkg::char_type'(digits[i]);
         entry.last      = (i == digits.size() - 1);
         expected_text.push_back(entry);
      end
   endfunction

   // predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_text(req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected response, expected none, got character %0d last %0b",
                        $time, rsp_character, rsp_last);
               failures++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character) begin
                  $display("%0t: character mismatch, expected %0d, got %0d",
                           $time, want.character, rsp_character);
                  failures++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch, expected %0b, got %0b",
                           $time, want.last, rsp_last);
                  failures++;
               end
            end
         end
      end
      error_count   <= failures;
      pending_count <= expected_text.size();
   end

endmodule

[tb/sv/signed_int_to_decimal_ascii_tb.sv]
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Testbench top for the signed integer to decimal text converter
// ---------------------------------------------------------------------------
// Sends a directed set of values (zero, single digits, powers of ten, both
// extremes of the range, alternating bit patterns) and then random values of
// mixed magnitude and sign. Both sides idle in random bursts, the receiver
// holds off once for a long stretch so the block backs up, and the last part
// of the run goes without idling. The checker module does all the checking.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

   localparam int VALUE_BITS      = 32;
   localparam int RANDOM_REQUESTS = 238;
   localparam int HOLD_START      = 100;
   localparam int HOLD_REQUESTS   = 8;
   localparam int QUIET_START     = 200;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 60;
   localparam int CYCLE_LIMIT     = 400000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [VALUE_BITS-1:0]  req_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [6:0]                    rsp_character;
   logic                          rsp_last;

   int   error_count;
   int   pending_count;
   int   cycle_count = 0;
   logic quiet;      // no idling on either side
   logic hold_rsp;   // ask the receiver for one long hold-off

   signed_int_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last)
   );

   decimal_text_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last),
      .error_count  (error_count),
      .pending_count(pending_count)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // random value of mixed magnitude, sign and bit pattern
   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] magnitude;
      int unsigned           scale;
      scale = 1;
      case ($urandom_range(0, 3))
         0: random_value = $urandom();
         1, 2: begin
            repeat ($urandom_range(1, 9)) scale = scale * 10;
            magnitude    = $urandom() % scale;
            random_value = $urandom_range(0, 1) ? -magnitude : magnitude;
         end
         default: begin
            if ($urandom_range(0, 1))
               random_value = 32'h8000_0000 + $urandom_range(0, 15);
            else
               random_value = 32'h7FFF_FFFF - $urandom_range(0, 15);
         end
      endcase
   endfunction

   // offer one request until accepted, then maybe idle for a burst
   task automatic send_request(input logic [VALUE_BITS-1:0] value);
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!quiet && !hold_rsp && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         req_value <= $urandom();
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // receiver: random stall bursts, one long hold-off, none when quiet
   initial begin
      logic stall_next;
      int   span;
      logic hold_done;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            stall_next = 1'b1;
            span       = HOLD_CYCLES;
            hold_done  = 1'b1;
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            stall_next = 1'b1;
            span       = $urandom_range(1, 11);
         end else begin
            stall_next = 1'b0;
            span       = $urandom_range(1, 20);
         end
         rsp_stall <= stall_next;
         repeat (span) @(posedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      logic [VALUE_BITS-1:0] directed_values[22];
      req_valid <= 1'b0;
      req_value <= '0;
      reset     <= 1'b1;
      quiet     <= 1'b0;
      hold_rsp  <= 1'b0;
      directed_values = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
                          32'd99, 32'd100, -32'sd100, 32'd999999999, 32'd1000000000,
                          -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                          32'd2147483640, 32'd123456789, -32'sd987654321, 32'd1999999999,
                          32'h5555_5555, 32'hAAAA_AAAA};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed values
      foreach (directed_values[i]) send_request(directed_values[i]);

      // random values with one long receiver hold-off and a quiet tail
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == HOLD_START) hold_rsp <= 1'b1;
         if (n == HOLD_START + HOLD_REQUESTS) hold_rsp <= 1'b0;
         if (n == QUIET_START) quiet <= 1'b1;
         send_request(random_value());
      end
      req_valid <= 1'b0;

      // drain
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
